@@ src/cspe_pkg.sv @@
// ----------------------------------------------------------------------------
// Cubic spline segment evaluator package
// Shared widths, stream layout, field codes and the saturation helper.
// ----------------------------------------------------------------------------
package cspe_pkg;

  localparam int VAL_W       = 32;
  localparam int OP_W        = 34;
  localparam int PROD_W      = 66;
  localparam int ACC_W       = 68;
  localparam int CFG_W       = 5;
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 200;
  localparam int OUT_PAD_W   = 3;

  localparam logic [1:0] MODE_KNOT  = 2'd0;
  localparam logic [1:0] MODE_COEF  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] TERM_A = 2'd0;
  localparam logic [1:0] TERM_B = 2'd1;
  localparam logic [1:0] TERM_C = 2'd2;
  localparam logic [1:0] TERM_D = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [3:0] COEF_LAST = 4'd11;

  localparam logic signed [ACC_W-1:0] ACC_S32_MAX = {{(ACC_W-VAL_W){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [ACC_W-1:0] ACC_S32_MIN = {{(ACC_W-VAL_W){1'b1}}, 32'h8000_0000};

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    ovf;
  } sat_t;

  function automatic sat_t sat_val(input logic signed [ACC_W-1:0] v);
    sat_t r;
    if (v > ACC_S32_MAX) begin
      r.value = 32'sh7FFF_FFFF;
      r.ovf   = 1'b1;
    end else if (v < ACC_S32_MIN) begin
      r.value = 32'sh8000_0000;
      r.ovf   = 1'b1;
    end else begin
      r.value = v[VAL_W-1:0];
      r.ovf   = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ src/cspe_ram.sv @@
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cspe_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/cubic_spline_segment_evaluator.sv @@
// ----------------------------------------------------------------------------
// Cubic spline segment evaluator
// A knot or coefficient write is accepted in the idle state. A query scans the
// knot RAM up to the clamped segment count one entry a cycle, then streams
// twelve coefficients through two multipliers, the position one shared with
// the dt powers; the result is registered once the pipeline drains and the
// output register is free, and the next item is taken back in the idle state.
// Reset clears control state and sets the segment count to one; the RAMs are not cleared.
// ----------------------------------------------------------------------------
module cubic_spline_segment_evaluator #(
  parameter int MAX_SEGMENTS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // entry_index, axis, term, write_value, query_time, zero padding
  input  logic [cspe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic [cspe_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pos_x, pos_y, pos_z, rate_x, rate_y, rate_z, chosen_segment,
  // overflow_flag, zero padding
  output logic [cspe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cspe_pkg::CFG_W-1:0]       cfg_data_i
);

  import cspe_pkg::*;

  localparam int KNOT_DEPTH = MAX_SEGMENTS + 1;
  localparam int COEF_DEPTH = MAX_SEGMENTS * 12;
  localparam int KA_W       = $clog2(KNOT_DEPTH);
  localparam int CA_W       = $clog2(COEF_DEPTH);
  localparam int SEG_W      = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic signed [OP_W-1:0] FIX_ONE = (OP_W'(1) << FRAC_BITS);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN     = 4'd1;
  localparam logic [3:0] S_SCAN_END = 4'd2;
  localparam logic [3:0] S_SEL      = 4'd3;
  localparam logic [3:0] S_DT2A     = 4'd4;
  localparam logic [3:0] S_DT2B     = 4'd5;
  localparam logic [3:0] S_DT3A     = 4'd6;
  localparam logic [3:0] S_DT3B     = 4'd7;
  localparam logic [3:0] S_COEF     = 4'd8;
  localparam logic [3:0] S_DRAIN    = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [CFG_W-1:0] seg_count_q;

  logic [1:0]              in_mode;
  logic [4:0]              in_idx;
  logic [1:0]              in_axis;
  logic [1:0]              in_term;
  logic signed [VAL_W-1:0] in_wv;
  logic signed [VAL_W-1:0] in_qt;
  logic                    accept;
  logic                    query_go;

  logic [KA_W-1:0]         n_eff;
  logic [KA_W-1:0]         n_q;
  logic signed [VAL_W-1:0] t_q;
  logic [KA_W-1:0]         scan_q;
  logic                    chk_vld_q;
  logic [KA_W-1:0]         chk_idx_q;
  logic signed [VAL_W-1:0] prev_q, k0_q, kfound_q, klast_q;
  logic                    le0_q, gen_q, found_q;
  logic [SEG_W-1:0]        fidx_q;
  logic signed [VAL_W-1:0] k_cur;
  logic                    hit;

  logic [SEG_W-1:0]        seg_sel, seg_q;
  logic signed [VAL_W-1:0] kseg_sel;
  logic [CA_W-1:0]         cbase_q;
  logic signed [ACC_W-1:0] t_ext, k_ext;
  sat_t                    dt_sat, prod_sat, sat_pos, sat_rate;
  logic signed [VAL_W-1:0] dt_q, dt2_q, dt3_q;
  logic signed [OP_W-1:0]  dt2x3_q;

  logic [3:0]              cnt_q;
  logic                    st1_vld_q, st2_vld_q, st3_vld_q;
  logic [3:0]              st1_tag_q, st2_tag_q;
  logic [1:0]              st3_axis_q;

  logic [VAL_W-1:0]         knot_rdata, coef_rdata;
  logic                     knot_we, coef_we;
  logic [CA_W-1:0]          coef_waddr, coef_raddr;

  logic signed [VAL_W-1:0]  mul_a;
  logic signed [OP_W-1:0]   mul_b_pos, mul_b_rate;
  logic signed [PROD_W-1:0] mul_pos, mul_rate;
  logic signed [PROD_W-1:0] prod_pos_q, prod_rate_q;
  logic signed [ACC_W-1:0]  pos_ext, rate_ext, pos_sh, rate_sh;
  logic signed [ACC_W-1:0]  acc_pos_q, acc_rate_q;
  logic signed [VAL_W-1:0]  res_pos_q [3];
  logic signed [VAL_W-1:0]  res_rate_q [3];
  logic                     ovf_q;
  logic                     out_vld_q;
  logic                     out_load;
  logic [OUT_TDATA_W-1:0]   out_data_q;

  assign in_mode  = s_axis_tuser[1:0];
  assign in_idx   = s_axis_tdata[4:0];
  assign in_axis  = s_axis_tdata[6:5];
  assign in_term  = s_axis_tdata[8:7];
  assign in_wv    = s_axis_tdata[40:9];
  assign in_qt    = s_axis_tdata[72:41];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign query_go      = accept && (in_mode == MODE_QUERY);
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    if (seg_count_q == '0) begin
      n_eff = KA_W'(1);
    end else if (32'(seg_count_q) > MAX_SEGMENTS) begin
      n_eff = KA_W'(MAX_SEGMENTS);
    end else begin
      n_eff = KA_W'(seg_count_q);
    end
  end

  assign knot_we    = accept && (in_mode == MODE_KNOT) && (32'(in_idx) <= MAX_SEGMENTS);
  assign coef_we    = accept && (in_mode == MODE_COEF) && (32'(in_idx) < MAX_SEGMENTS) &&
                      (in_axis <= AXIS_Z);
  assign coef_waddr = CA_W'({in_idx, 3'b000}) + CA_W'({in_idx, 2'b00}) +
                      CA_W'({in_axis, in_term});
  assign coef_raddr = cbase_q + CA_W'(cnt_q);

  cspe_ram #(
    .DATA_W(VAL_W),
    .DEPTH (KNOT_DEPTH)
  ) u_knot_ram (
    .clk_i  (clk_i),
    .we_i   (knot_we),
    .waddr_i(KA_W'(in_idx)),
    .wdata_i(in_wv),
    .raddr_i(scan_q),
    .rdata_o(knot_rdata)
  );

  cspe_ram #(
    .DATA_W(VAL_W),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (coef_we),
    .waddr_i(coef_waddr),
    .wdata_i(in_wv),
    .raddr_i(coef_raddr),
    .rdata_o(coef_rdata)
  );

  assign k_cur = knot_rdata;
  assign hit   = chk_vld_q && (chk_idx_q != '0) && !found_q &&
                 (prev_q <= t_q) && (t_q <= k_cur);

  always_comb begin
    if (le0_q) begin
      seg_sel  = '0;
      kseg_sel = k0_q;
    end else if (gen_q || !found_q) begin
      seg_sel  = SEG_W'(n_q - KA_W'(1));
      kseg_sel = klast_q;
    end else begin
      seg_sel  = fidx_q;
      kseg_sel = kfound_q;
    end
  end

  assign t_ext  = {{(ACC_W-VAL_W){t_q[VAL_W-1]}}, t_q};
  assign k_ext  = {{(ACC_W-VAL_W){kseg_sel[VAL_W-1]}}, kseg_sel};
  assign dt_sat = sat_val(t_ext - k_ext);

  always_comb begin
    case (state_q)
      S_DT2A: begin
        mul_a     = dt_q;
        mul_b_pos = {{(OP_W-VAL_W){dt_q[VAL_W-1]}}, dt_q};
      end
      S_DT3A: begin
        mul_a     = dt2_q;
        mul_b_pos = {{(OP_W-VAL_W){dt_q[VAL_W-1]}}, dt_q};
      end
      default: begin
        mul_a = coef_rdata;
        case (st1_tag_q[1:0])
          TERM_A:  mul_b_pos = FIX_ONE;
          TERM_B:  mul_b_pos = {{(OP_W-VAL_W){dt_q[VAL_W-1]}}, dt_q};
          TERM_C:  mul_b_pos = {{(OP_W-VAL_W){dt2_q[VAL_W-1]}}, dt2_q};
          default: mul_b_pos = {{(OP_W-VAL_W){dt3_q[VAL_W-1]}}, dt3_q};
        endcase
      end
    endcase
  end

  always_comb begin
    case (st1_tag_q[1:0])
      TERM_A:  mul_b_rate = '0;
      TERM_B:  mul_b_rate = FIX_ONE;
      TERM_C:  mul_b_rate = {{(OP_W-VAL_W-1){dt_q[VAL_W-1]}}, dt_q, 1'b0};
      default: mul_b_rate = dt2x3_q;
    endcase
  end

  assign mul_pos  = mul_a * mul_b_pos;
  assign mul_rate = mul_a * mul_b_rate;

  assign pos_ext  = {{(ACC_W-PROD_W){prod_pos_q[PROD_W-1]}}, prod_pos_q};
  assign rate_ext = {{(ACC_W-PROD_W){prod_rate_q[PROD_W-1]}}, prod_rate_q};
  assign pos_sh   = pos_ext >>> FRAC_BITS;
  assign rate_sh  = rate_ext >>> FRAC_BITS;
  assign prod_sat = sat_val(pos_sh);
  assign sat_pos  = sat_val(acc_pos_q);
  assign sat_rate = sat_val(acc_rate_q);

  assign out_load = (state_q == S_DONE) && (!out_vld_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (query_go) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_q == n_q) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: state_d = S_SEL;
      S_SEL:      state_d = S_DT2A;
      S_DT2A:     state_d = S_DT2B;
      S_DT2B:     state_d = S_DT3A;
      S_DT3A:     state_d = S_DT3B;
      S_DT3B:     state_d = S_COEF;
      S_COEF: begin
        if (cnt_q == COEF_LAST) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (st3_vld_q && (st3_axis_q == AXIS_Z)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seg_count_q <= CFG_W'(1);
      chk_vld_q   <= 1'b0;
      st1_vld_q   <= 1'b0;
      st2_vld_q   <= 1'b0;
      st3_vld_q   <= 1'b0;
      out_vld_q   <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= (state_q == S_SCAN);
      st1_vld_q <= (state_q == S_COEF);
      st2_vld_q <= st1_vld_q;
      st3_vld_q <= st2_vld_q && (st2_tag_q[1:0] == TERM_D);
      if (cfg_valid_i && cfg_ready_o) begin
        seg_count_q <= cfg_data_i;
      end
      if (query_go) begin
        found_q <= 1'b0;
      end else if (hit) begin
        found_q <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_go) begin
      t_q    <= in_qt;
      n_q    <= n_eff;
      scan_q <= '0;
      ovf_q  <= 1'b0;
    end
    if ((state_q == S_SCAN) && (scan_q != n_q)) begin
      scan_q <= scan_q + KA_W'(1);
    end
    chk_idx_q <= scan_q;

    if (chk_vld_q) begin
      prev_q <= k_cur;
      if (chk_idx_q == '0) begin
        k0_q  <= k_cur;
        le0_q <= (t_q <= k_cur);
      end
      if (hit) begin
        fidx_q   <= SEG_W'(chk_idx_q - KA_W'(1));
        kfound_q <= prev_q;
      end
      if (chk_idx_q == n_q) begin
        gen_q   <= (t_q >= k_cur);
        klast_q <= prev_q;
      end
    end

    case (state_q)
      S_SEL: begin
        seg_q   <= seg_sel;
        cbase_q <= CA_W'({seg_sel, 3'b000}) + CA_W'({seg_sel, 2'b00});
        dt_q    <= dt_sat.value;
        ovf_q   <= ovf_q | dt_sat.ovf;
      end
      S_DT2B: begin
        dt2_q <= prod_sat.value;
        ovf_q <= ovf_q | prod_sat.ovf;
      end
      S_DT3A: begin
        dt2x3_q <= {{(OP_W-VAL_W-1){dt2_q[VAL_W-1]}}, dt2_q, 1'b0} +
                   {{(OP_W-VAL_W){dt2_q[VAL_W-1]}}, dt2_q};
      end
      S_DT3B: begin
        dt3_q <= prod_sat.value;
        ovf_q <= ovf_q | prod_sat.ovf;
        cnt_q <= '0;
      end
      S_COEF: begin
        cnt_q <= cnt_q + 4'd1;
      end
      default: begin
      end
    endcase

    prod_pos_q  <= mul_pos;
    prod_rate_q <= mul_rate;
    st1_tag_q   <= cnt_q;
    st2_tag_q   <= st1_tag_q;
    st3_axis_q  <= st2_tag_q[3:2];

    if (st2_vld_q) begin
      if (st2_tag_q[1:0] == TERM_A) begin
        acc_pos_q  <= pos_sh;
        acc_rate_q <= rate_sh;
      end else begin
        acc_pos_q  <= acc_pos_q + pos_sh;
        acc_rate_q <= acc_rate_q + rate_sh;
      end
    end

    if (st3_vld_q) begin
      ovf_q <= ovf_q | sat_pos.ovf | sat_rate.ovf;
      case (st3_axis_q)
        AXIS_X: begin
          res_pos_q[0]  <= sat_pos.value;
          res_rate_q[0] <= sat_rate.value;
        end
        AXIS_Y: begin
          res_pos_q[1]  <= sat_pos.value;
          res_rate_q[1] <= sat_rate.value;
        end
        AXIS_Z: begin
          res_pos_q[2]  <= sat_pos.value;
          res_rate_q[2] <= sat_rate.value;
        end
        default: begin
        end
      endcase
    end

    if (out_load) begin
      out_data_q <= {{OUT_PAD_W{1'b0}}, ovf_q, 4'(seg_q),
                     res_rate_q[2], res_rate_q[1], res_rate_q[0],
                     res_pos_q[2], res_pos_q[1], res_pos_q[0]};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> (chk_idx_q <= n_q))
    else $error("knot scan read past the last used knot");

  a_seg_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COEF) |-> (32'(seg_q) < 32'(n_q)))
    else $error("selected segment is not below the segment count");

  a_drained_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (!st1_vld_q && !st2_vld_q && !st3_vld_q))
    else $error("coefficient pipeline still busy when the result is ready");

  a_flag_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_go |=> !ovf_q)
    else $error("overflow flag not cleared at query start");

endmodule
